FILE: design/tem_pkg.sv
// shared types, constants and helpers for the track eviction monitor
package tem_pkg;

  // tick arithmetic width and the largest valid location timestamp
  localparam int unsigned TICK_BITS = 32;
  localparam int unsigned CMP_BITS  = (TICK_BITS > 32) ? TICK_BITS : 32;
  localparam logic [15:0] TS_MAX    = 16'd36000;

  // apb register map
  localparam int unsigned ADDR_BITS = 4;
  localparam logic [1:0]  REG_LAND   = 2'd0;
  localparam logic [1:0]  REG_SILENT = 2'd1;
  localparam logic [1:0]  REG_FROZEN = 2'd2;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [CMP_BITS-1:0]  cmp_t;

  typedef enum logic [2:0] {
    VERDICT_KEEP      = 3'd0,
    VERDICT_LANDED    = 3'd1,
    VERDICT_SILENT    = 3'd2,
    VERDICT_NO_FRAMES = 3'd3,
    VERDICT_FROZEN    = 3'd4
  } verdict_e;

  // one observation
  typedef struct packed {
    logic [31:0] now_tick;
    logic        frame_seen;
    logic        state_seen;
    logic        is_airborne;
    logic        was_ever_airborne;
    logic        loc_seen;
    logic [15:0] loc_stamp;
  } in_item_t;

  // one verdict
  typedef struct packed {
    logic [2:0] verdict;
  } out_item_t;

  // eviction limits
  typedef struct packed {
    logic [31:0] land_limit;
    logic [31:0] silent_limit;
    logic [31:0] frozen_limit;
  } limits_t;

  // wrap-around elapsed time strictly above a limit
  function automatic logic over_limit(tick_t from_t, tick_t to_t, logic [31:0] lim);
    tick_t diff;
    diff = to_t - from_t;
    return cmp_t'(diff) > cmp_t'(lim);
  endfunction

endpackage

FILE: design/tem_if.sv
// valid/ready channel interfaces for observations and verdicts

interface tem_in_if import tem_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface tem_out_if import tem_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: design/track_eviction_monitor.sv
// top level of the track eviction monitor: input and result registers around the core
//
//   port        dir   handshake     carries
//   in_i        in    valid/ready   observation: tick, frame/state/location flags, stamp
//   out_o       out   valid/ready   verdict, one per observation
//   apb         in    psel/penable  land, silent and frozen limits at 0x0, 0x4, 0x8
//
// one item per cycle sustained while out_o.ready holds; a verdict is offered once its item
// has passed the input register, then the verdict logic into the result register
// reset clears the tracker state and sets all limits to all ones
// while the result register is stalled the input register still takes one more item;
// ready drops only when both registers are full and the result is not taken
module track_eviction_monitor import tem_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tem_in_if.sink               in_i,
  tem_out_if.source            out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  limits_t   limits;
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;
  verdict_e  verdict;

  tem_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .limits_o (limits)
  );

  tem_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (s1_item_q),
    .limits_i  (limits),
    .verdict_o (verdict)
  );

  // handshake
  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.item;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q.verdict <= verdict;
    end
  end

  // an accepted item is held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s1_valid_q)
    else $error("accepted item lost");

  // a waiting item is not dropped while the result stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_o.ready |=> s1_valid_q && out_valid_q)
    else $error("item dropped during stall");

  // a committed item always produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("committed item produced no result");

endmodule

FILE: design/tem_cfg.sv
// apb register block holding the three eviction limits
module tem_cfg import tem_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output limits_t              limits_o
);

  limits_t    limits_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = paddr[3:2];
  assign limits_o = limits_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.land_limit   <= '1;
      limits_q.silent_limit <= '1;
      limits_q.frozen_limit <= '1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LAND:   limits_q.land_limit   <= pwdata;
        REG_SILENT: limits_q.silent_limit <= pwdata;
        REG_FROZEN: limits_q.frozen_limit <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_LAND:   prdata = limits_q.land_limit;
      REG_SILENT: prdata = limits_q.silent_limit;
      REG_FROZEN: prdata = limits_q.frozen_limit;
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: design/tem_core.sv
// tracker state, per-item update and verdict logic
module tem_core import tem_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  input  limits_t  limits_i,
  output verdict_e verdict_o
);

  logic        any_frame_valid_q, any_frame_valid_d;
  tick_t       last_frame_time_q, last_frame_time_d;
  logic        airborne_valid_q, airborne_valid_d;
  tick_t       last_airborne_time_q, last_airborne_time_d;
  logic        grounded_valid_q, grounded_valid_d;
  tick_t       grounded_since_q, grounded_since_d;
  logic        stamp_valid_q, stamp_valid_d;
  logic [15:0] held_stamp_q, held_stamp_d;
  tick_t       stamp_changed_time_q, stamp_changed_time_d;
  tick_t       stamp_seen_time_q, stamp_seen_time_d;
  tick_t       now;

  assign now = tick_t'(item_i.now_tick);

  // frame, airborne and location updates in that order
  always_comb begin
    any_frame_valid_d    = any_frame_valid_q;
    last_frame_time_d    = last_frame_time_q;
    airborne_valid_d     = airborne_valid_q;
    last_airborne_time_d = last_airborne_time_q;
    grounded_valid_d     = grounded_valid_q;
    grounded_since_d     = grounded_since_q;
    stamp_valid_d        = stamp_valid_q;
    held_stamp_d         = held_stamp_q;
    stamp_changed_time_d = stamp_changed_time_q;
    stamp_seen_time_d    = stamp_seen_time_q;

    if (item_i.frame_seen) begin
      any_frame_valid_d = 1'b1;
      last_frame_time_d = now;
    end

    if (item_i.state_seen) begin
      if (item_i.is_airborne) begin
        airborne_valid_d     = 1'b1;
        last_airborne_time_d = now;
        grounded_valid_d     = 1'b0;
      end else if (item_i.was_ever_airborne && !grounded_valid_q) begin
        grounded_valid_d = 1'b1;
        grounded_since_d = now;
      end
    end

    if (item_i.loc_seen) begin
      if (item_i.loc_stamp > TS_MAX) begin
        stamp_valid_d = 1'b0;
      end else begin
        if (!stamp_valid_q || (held_stamp_q != item_i.loc_stamp)) begin
          stamp_valid_d        = 1'b1;
          held_stamp_d         = item_i.loc_stamp;
          stamp_changed_time_d = now;
        end
        stamp_seen_time_d = now;
      end
    end
  end

  // priority verdict on the updated state
  always_comb begin
    if (grounded_valid_d && over_limit(grounded_since_d, now, limits_i.land_limit)) begin
      verdict_o = VERDICT_LANDED;
    end else if (airborne_valid_d &&
                 over_limit(last_airborne_time_d, now, limits_i.silent_limit)) begin
      verdict_o = VERDICT_SILENT;
    end else if (any_frame_valid_d &&
                 over_limit(last_frame_time_d, now, limits_i.silent_limit)) begin
      verdict_o = VERDICT_NO_FRAMES;
    end else if (stamp_valid_d && over_limit(stamp_changed_time_d, stamp_seen_time_d,
                                             limits_i.frozen_limit)) begin
      verdict_o = VERDICT_FROZEN;
    end else begin
      verdict_o = VERDICT_KEEP;
    end
  end

  // state commits when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_frame_valid_q    <= 1'b0;
      last_frame_time_q    <= '0;
      airborne_valid_q     <= 1'b0;
      last_airborne_time_q <= '0;
      grounded_valid_q     <= 1'b0;
      grounded_since_q     <= '0;
      stamp_valid_q        <= 1'b0;
      held_stamp_q         <= '0;
      stamp_changed_time_q <= '0;
      stamp_seen_time_q    <= '0;
    end else if (step_i) begin
      any_frame_valid_q    <= any_frame_valid_d;
      last_frame_time_q    <= last_frame_time_d;
      airborne_valid_q     <= airborne_valid_d;
      last_airborne_time_q <= last_airborne_time_d;
      grounded_valid_q     <= grounded_valid_d;
      grounded_since_q     <= grounded_since_d;
      stamp_valid_q        <= stamp_valid_d;
      held_stamp_q         <= held_stamp_d;
      stamp_changed_time_q <= stamp_changed_time_d;
      stamp_seen_time_q    <= stamp_seen_time_d;
    end
  end

  // airborne report clears the grounded mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.state_seen && item_i.is_airborne
      |=> airborne_valid_q && !grounded_valid_q)
    else $error("airborne report did not clear grounded mark");

  // frame time recorded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.frame_seen |=> any_frame_valid_q && (last_frame_time_q == $past(now)))
    else $error("frame time not recorded");

  // no state change without a committed item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(stamp_valid_q) && $stable(held_stamp_q) && $stable(grounded_valid_q))
    else $error("state changed without an item");

endmodule
